// File: hw/rtl/frt_pkg.sv
// ----------------------------------------------------------------------------
// Fractional-rate timer package
// Shared codes, masks and types for the timer, its divider and its checker.
// ----------------------------------------------------------------------------
package frt_pkg;

  // Item kinds carried in the low bits of the input tuser.
  localparam logic [1:0] ModeRead  = 2'd0;
  localparam logic [1:0] ModeWrite = 2'd1;
  localparam logic [1:0] ModeTick  = 2'd2;
  // Unused kind: changes nothing and reads zero.
  localparam logic [1:0] ModeNone  = 2'd3;

  // Register selectors.
  localparam logic [2:0] RegIntr     = 3'd0;
  localparam logic [2:0] RegIntrEn   = 3'd1;
  localparam logic [2:0] RegNum      = 3'd2;
  localparam logic [2:0] RegDen      = 3'd3;
  localparam logic [2:0] RegTimeLow  = 3'd4;
  localparam logic [2:0] RegTimeHigh = 3'd5;
  localparam logic [2:0] RegAlarm    = 3'd6;
  localparam logic [2:0] RegNone     = 3'd7;

  // Field widths.
  localparam int unsigned RateW  = 16;
  localparam int unsigned WordW  = 32;
  localparam int unsigned TimeW  = 64;

  // Time halves and the alarm keep bits 31:5 only.
  localparam logic [WordW-1:0] TimeKeepMask = 32'hFFFF_FFE0;
  localparam logic [WordW-1:0] RateMask     = 32'h0000_FFFF;
  localparam logic [WordW-1:0] AlarmBit     = 32'h0000_0001;

  // Divider status seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: hw/rtl/frt_div.sv
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring 32-by-16 unsigned division, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module frt_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [frt_pkg::WordW-1:0]       dividend_i,
  input  logic [frt_pkg::RateW-1:0]       divisor_i,
  output logic [frt_pkg::WordW-1:0]       quotient_o,
  output frt_pkg::div_stat_t              stat_o
);

  localparam int unsigned Steps = frt_pkg::WordW / 2;
  localparam int unsigned CntW  = $clog2(Steps);

  logic [frt_pkg::RateW-1:0] rem_q, rem_d;
  logic [frt_pkg::WordW-1:0] quo_q, quo_d;
  logic [frt_pkg::RateW-1:0] den_q, den_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic                      busy_q, busy_d;
  logic                      done_q, done_d;

  logic [frt_pkg::RateW:0]   trial1, trial2, den_ext;
  logic [frt_pkg::RateW-1:0] rem1, rem2;
  logic                      ge1, ge2;

  // Two dependent restoring steps: shift in a dividend bit, subtract if it fits.
  always_comb begin
    den_ext = {1'b0, den_q};
    trial1  = {rem_q, quo_q[frt_pkg::WordW-1]};
    ge1     = (trial1 >= den_ext);
    rem1    = ge1 ? 16'(trial1 - den_ext) : trial1[frt_pkg::RateW-1:0];
    trial2  = {rem1, quo_q[frt_pkg::WordW-2]};
    ge2     = (trial2 >= den_ext);
    rem2    = ge2 ? 16'(trial2 - den_ext) : trial2[frt_pkg::RateW-1:0];
  end

  // Iteration control.
  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      den_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = rem2;
      quo_d = {quo_q[frt_pkg::WordW-3:0], ge1, ge2};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(Steps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// File: hw/rtl/fractional_rate_timer_with_alarm.sv
// ----------------------------------------------------------------------------
// Fractional-rate timer with alarm
// 64-bit time count advanced by scaled tick counts, with an alarm compare.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on the slave stream. The tuser kind says whether a beat is a
// bus read, a bus write or a timer tick; bus beats name a register and carry
// write data, tick beats carry a count of elapsed base clock cycles.
// Every beat produces exactly one result beat on the master stream with the
// read data (zero unless a read) and the alarm status and interrupt flags.
// Reads, writes, unused kinds and ticks while the numerator or denominator
// is zero finish at once: the result is valid the cycle after acceptance,
// one item per cycle while the receiver takes each result. A tick with both
// nonzero runs a multiply, a 16-step iterative divide (two quotient bits a
// cycle), a 64-bit add and the alarm compare through the states Mul, DivLoad,
// Div, Add and Cmp; the next beat waits until the sequencer is back in idle.
// Input ready drops while a tick is in work and while a result is stalled by
// the receiver; a stalled result holds its payload.
// Reset zeroes the architectural registers and empties the output register.
// ----------------------------------------------------------------------------
module fractional_rate_timer_with_alarm (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // write_data [31:0], elapsed_cycles [47:32]
  input  logic [47:0] s_axis_tdata_i,
  // mode [1:0], reg_select [4:2]
  input  logic [4:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // read_data [31:0]
  output logic [31:0] m_axis_tdata_o,
  // alarm_pending [0], irq [1]
  output logic [1:0]  m_axis_tuser_o
);

  localparam logic [2:0] StIdle    = 3'd0;
  localparam logic [2:0] StMul     = 3'd1;
  localparam logic [2:0] StDivLoad = 3'd2;
  localparam logic [2:0] StDiv     = 3'd3;
  localparam logic [2:0] StAdd     = 3'd4;
  localparam logic [2:0] StCmp     = 3'd5;

  logic [2:0] state_q, state_d;

  // Architectural registers.
  logic                          flag_q, flag_d;
  logic                          en_q, en_d;
  logic [frt_pkg::RateW-1:0]     num_q, num_d;
  logic [frt_pkg::RateW-1:0]     den_q, den_d;
  logic [frt_pkg::TimeW-1:0]     time_q, time_d;
  logic [frt_pkg::WordW-1:0]     alarm_q, alarm_d;

  // Tick datapath.
  logic [frt_pkg::RateW-1:0]     cyc_q, cyc_d;
  logic [frt_pkg::WordW-1:0]     prod_q, prod_d;
  logic [frt_pkg::WordW-1:0]     quotient;
  frt_pkg::div_stat_t            div_stat;

  // Output register.
  logic                          m_valid_q, m_valid_d;
  logic [frt_pkg::WordW-1:0]     m_data_q, m_data_d;
  logic [1:0]                    m_user_q, m_user_d;

  logic                          accept;
  logic                          out_load;
  logic [frt_pkg::WordW-1:0]     rd_value;
  logic [1:0]                    in_mode;
  logic [2:0]                    in_sel;
  logic [frt_pkg::WordW-1:0]     in_data;
  logic [frt_pkg::RateW-1:0]     in_cycles;
  logic                          alarm_reached;

  assign in_data   = s_axis_tdata_i[31:0];
  assign in_cycles = s_axis_tdata_i[47:32];
  assign in_mode   = s_axis_tuser_i[1:0];
  assign in_sel    = s_axis_tuser_i[4:2];

  assign s_axis_tready_o = (state_q == StIdle) && (!m_valid_q || m_axis_tready_i);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // Divider for the rate scaling.
  frt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == StDivLoad),
    .dividend_i (prod_q),
    .divisor_i  (den_q),
    .quotient_o (quotient),
    .stat_o     (div_stat)
  );

  // Register read mux.
  always_comb begin
    unique case (in_sel)
      frt_pkg::RegIntr:     rd_value = {31'd0, flag_q};
      frt_pkg::RegIntrEn:   rd_value = {31'd0, en_q};
      frt_pkg::RegNum:      rd_value = {16'd0, num_q};
      frt_pkg::RegDen:      rd_value = {16'd0, den_q};
      frt_pkg::RegTimeLow:  rd_value = time_q[31:0];
      frt_pkg::RegTimeHigh: rd_value = time_q[63:32];
      frt_pkg::RegAlarm:    rd_value = alarm_q;
      default:              rd_value = '0;
    endcase
  end

  // The time count is compared against the zero-extended alarm.
  assign alarm_reached = (time_q[63:32] != 32'd0) || (time_q[31:0] >= alarm_q);

  // Sequencer and register updates.
  always_comb begin
    state_d  = state_q;
    flag_d   = flag_q;
    en_d     = en_q;
    num_d    = num_q;
    den_d    = den_q;
    time_d   = time_q;
    alarm_d  = alarm_q;
    cyc_d    = cyc_q;
    prod_d   = prod_q;
    out_load = 1'b0;
    m_data_d = m_data_q;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          m_data_d = '0;
          unique case (in_mode)
            frt_pkg::ModeRead: begin
              m_data_d = rd_value;
              out_load = 1'b1;
            end
            frt_pkg::ModeWrite: begin
              out_load = 1'b1;
              unique case (in_sel)
                frt_pkg::RegIntr: begin
                  if ((in_data & frt_pkg::AlarmBit) != '0) flag_d = 1'b0;
                end
                frt_pkg::RegIntrEn:   en_d = in_data[0];
                frt_pkg::RegNum:      num_d = in_data[15:0];
                frt_pkg::RegDen: begin
                  den_d = (in_data == '0) ? 16'd1 : in_data[15:0];
                end
                frt_pkg::RegTimeLow: begin
                  time_d = {time_q[63:32], in_data & frt_pkg::TimeKeepMask};
                end
                frt_pkg::RegTimeHigh: begin
                  time_d = {in_data & frt_pkg::TimeKeepMask, time_q[31:0]};
                end
                frt_pkg::RegAlarm:    alarm_d = in_data & frt_pkg::TimeKeepMask;
                default: ;
              endcase
            end
            frt_pkg::ModeTick: begin
              if (num_q != '0 && den_q != '0) begin
                cyc_d   = in_cycles;
                state_d = StMul;
              end else begin
                out_load = 1'b1;
              end
            end
            default: out_load = 1'b1;
          endcase
        end
      end
      StMul: begin
        prod_d  = {16'd0, cyc_q} * {16'd0, num_q};
        state_d = StDivLoad;
      end
      StDivLoad: state_d = StDiv;
      StDiv: begin
        if (div_stat.done) state_d = StAdd;
      end
      StAdd: begin
        time_d  = time_q + {32'd0, quotient};
        state_d = StCmp;
      end
      StCmp: begin
        if (alarm_reached) flag_d = 1'b1;
        m_data_d = '0;
        out_load = 1'b1;
        state_d  = StIdle;
      end
      default: state_d = StIdle;
    endcase

    m_user_d  = out_load ? {flag_d & en_d, flag_d} : m_user_q;
    m_valid_d = out_load ? 1'b1 : (m_valid_q && !m_axis_tready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      flag_q    <= 1'b0;
      en_q      <= 1'b0;
      num_q     <= '0;
      den_q     <= '0;
      time_q    <= '0;
      alarm_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      flag_q    <= flag_d;
      en_q      <= en_d;
      num_q     <= num_d;
      den_q     <= den_d;
      time_q    <= time_d;
      alarm_q   <= alarm_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    cyc_q    <= cyc_d;
    prod_q   <= prod_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

endmodule

// File: hw/rtl/frt_checker.sv
// ----------------------------------------------------------------------------
// Fractional-rate timer checker
// Port-level assertions on the timer streams, bound to the top level.
// ----------------------------------------------------------------------------
module frt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_i,
  input logic [4:0]  s_axis_tuser_i,
  input logic        m_axis_tvalid_i,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_i,
  input logic [1:0]  m_axis_tuser_i
);

  logic in_beat;
  assign in_beat = s_axis_tvalid_i && s_axis_tready_i;

  // A stalled result beat keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=>
      m_axis_tvalid_i && $stable(m_axis_tdata_i) && $stable(m_axis_tuser_i))
    else $error("stalled result beat changed");

  // The interrupt line is never raised without the alarm status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |-> !(m_axis_tuser_i[1] && !m_axis_tuser_i[0]))
    else $error("irq set without alarm pending");

  // No new beat is taken while a result is held back by the receiver.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |-> !s_axis_tready_i)
    else $error("input accepted while result stalled");

  // Any beat other than a tick answers in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && (s_axis_tuser_i[1:0] != frt_pkg::ModeTick) |=> m_axis_tvalid_i)
    else $error("bus beat result missing");

  // A read of the unused selector returns zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && (s_axis_tuser_i[1:0] == frt_pkg::ModeRead) &&
      (s_axis_tuser_i[4:2] == frt_pkg::RegNone) |=> m_axis_tdata_i == 32'd0)
    else $error("unused selector read nonzero");

endmodule

bind fractional_rate_timer_with_alarm frt_checker u_frt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_i (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tuser_i  (m_axis_tuser_o)
);
